/* src/tcs_pkg.sv */
// shared types and character constants for the template code segmenter
package tcs_pkg;

    // character classes kept in the history line
    typedef enum logic [3:0] {
        CLS_OTHER = 4'd0,
        CLS_NL    = 4'd1,
        CLS_QUES  = 4'd2,
        CLS_GT    = 4'd3,
        CLS_LT    = 4'd4,
        CLS_EQ    = 4'd5,
        CLS_P     = 4'd6,
        CLS_Y     = 4'd7,
        CLS_T     = 4'd8,
        CLS_H     = 4'd9,
        CLS_O     = 4'd10,
        CLS_N     = 4'd11,
        CLS_TAB   = 4'd12,
        CLS_SP    = 4'd13
    } cls_t;

    // segment kinds on the result channel
    typedef enum logic [1:0] {
        SEG_END    = 2'd0,
        SEG_RAW    = 2'd1,
        SEG_INLINE = 2'd2,
        SEG_BLOCK  = 2'd3
    } seg_kind_t;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_QUES = 8'h3F;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_Y    = 8'h79;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_H    = 8'h68;
    localparam logic [7:0] CH_O    = 8'h6F;
    localparam logic [7:0] CH_N    = 8'h6E;

    localparam int HIST_DEPTH   = 9;
    localparam int MAX_RESULTS  = 3;
    localparam int INLINE_LEN   = 3;   // length of "<?="
    localparam int BLOCK_LEN    = 8;   // length of "<?python"

endpackage

/* src/template_code_segmenter.sv */
// top level of the template code segmenter: opener tracking and result queue
//
// The block takes a template text one character per s_ transaction and cuts
// it into raw-text and embedded-code segments, reported on the m_ side as
// kind plus start and end positions. Inline code opens with "<?=" and must
// close with "?>" on the same line with at least one code character; block
// code opens with "<?python" and a space, tab or newline, with at least one
// more character before "?>". The earliest opener after the last closed
// segment wins. A closing "?>" yields the raw text before the opener (when
// not empty) and then the code segment. The transaction with s_tlast adds
// the raw tail (when not empty) and an end marker, and the block starts
// over for a new text. Positions saturate at 2**POS_BITS-1. Each character
// is classified and all opener and closer checks are done combinationally
// on accept, so one transaction is taken per clock unless the result queue
// holds the input back. Results go through a three-entry queue that drains
// one per cycle while m_tready is high; a new transaction is taken while the
// queue holds at most the one result leaving in that cycle, so a character
// that closes a segment holds off input until only its last result is left.
module template_code_segmenter #(
    parameter int POS_BITS  = 16,
    parameter int CHAR_BITS = 21
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input: tdata = char_code, tuser = char_present, tlast = is_last
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((CHAR_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // char_code
    input  logic                                   s_tuser,  // char_present
    input  logic                                   s_tlast,  // is_last
    // result: tdata = seg_start, seg_end; tuser = seg_type; tlast = last_of_run
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((2 * POS_BITS + 7) / 8) * 8 - 1:0] m_tdata, // seg_start, seg_end
    output logic [1:0]                             m_tuser,  // seg_type
    output logic                                   m_tlast   // last_of_run
);
    import tcs_pkg::*;

    localparam int M_DATA_W = ((2 * POS_BITS + 7) / 8) * 8;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    // tracking state
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] seg_begin_reg, seg_begin_next;
    cls_t                hist_reg [HIST_DEPTH];
    cls_t                hist_next [HIST_DEPTH];
    logic [POS_BITS-1:0] bpos_reg, bpos_next;
    logic                bvalid_reg, bvalid_next;
    logic [POS_BITS-1:0] ipos_reg, ipos_next;
    logic                ivalid_reg, ivalid_next;

    // result queue, slot 0 is the head
    seg_kind_t           q_kind_reg [MAX_RESULTS];
    logic [POS_BITS-1:0] q_start_reg [MAX_RESULTS];
    logic [POS_BITS-1:0] q_end_reg [MAX_RESULTS];
    logic                q_last_reg [MAX_RESULTS];
    logic [1:0]          q_count_reg;

    // new results from the accepted transaction
    seg_kind_t           n_kind [MAX_RESULTS];
    logic [POS_BITS-1:0] n_start [MAX_RESULTS];
    logic [POS_BITS-1:0] n_end [MAX_RESULTS];
    logic                n_last [MAX_RESULTS];
    logic [1:0]          n_count;

    logic                s_accept, m_pop;
    logic [CHAR_BITS-1:0] chr;
    cls_t                cls;
    logic [POS_BITS:0]   cur_w, sb_w;
    logic                inl_hit, blk_hit, close_hit, iq, bq, use_inline;
    logic [POS_BITS-1:0] opener, code_start, code_stop;
    logic                ivalid_nl;
    logic [POS_BITS-1:0] sb_after, pos_after;

    // candidate results in emission order: raw before code, code, tail, end
    logic                c_en [4];
    seg_kind_t           c_kind [4];
    logic [POS_BITS-1:0] c_start [4];
    logic [POS_BITS-1:0] c_end [4];
    logic [2:0]          c_n;

    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (q_count_reg == 2'd0) || (q_count_reg == 2'd1 && m_tready);

    assign m_tvalid = (q_count_reg != 2'd0);
    assign m_tuser  = q_kind_reg[0];
    assign m_tlast  = q_last_reg[0];
    assign m_tdata  = M_DATA_W'({q_end_reg[0], q_start_reg[0]});

    assign chr = s_tdata[CHAR_BITS-1:0];

    // character classification
    always_comb begin
        if (chr == CHAR_BITS'(CH_NL))        cls = CLS_NL;
        else if (chr == CHAR_BITS'(CH_QUES)) cls = CLS_QUES;
        else if (chr == CHAR_BITS'(CH_GT))   cls = CLS_GT;
        else if (chr == CHAR_BITS'(CH_LT))   cls = CLS_LT;
        else if (chr == CHAR_BITS'(CH_EQ))   cls = CLS_EQ;
        else if (chr == CHAR_BITS'(CH_P))    cls = CLS_P;
        else if (chr == CHAR_BITS'(CH_Y))    cls = CLS_Y;
        else if (chr == CHAR_BITS'(CH_T))    cls = CLS_T;
        else if (chr == CHAR_BITS'(CH_H))    cls = CLS_H;
        else if (chr == CHAR_BITS'(CH_O))    cls = CLS_O;
        else if (chr == CHAR_BITS'(CH_N))    cls = CLS_N;
        else if (chr == CHAR_BITS'(CH_TAB))  cls = CLS_TAB;
        else if (chr == CHAR_BITS'(CH_SP))   cls = CLS_SP;
        else                                 cls = CLS_OTHER;
    end

    assign cur_w = {1'b0, pos_reg};
    assign sb_w  = {1'b0, seg_begin_reg};

    // opener and closer detection; hist_reg[k] is the character k+1 back
    assign inl_hit = (cls == CLS_EQ) && (hist_reg[0] == CLS_QUES)
                     && (hist_reg[1] == CLS_LT)
                     && (cur_w >= sb_w + (POS_BITS+1)'(INLINE_LEN - 1));
    assign blk_hit = (cls == CLS_SP || cls == CLS_NL || cls == CLS_TAB)
                     && (hist_reg[0] == CLS_N) && (hist_reg[1] == CLS_O)
                     && (hist_reg[2] == CLS_H) && (hist_reg[3] == CLS_T)
                     && (hist_reg[4] == CLS_Y) && (hist_reg[5] == CLS_P)
                     && (hist_reg[6] == CLS_QUES) && (hist_reg[7] == CLS_LT)
                     && (cur_w >= sb_w + (POS_BITS+1)'(BLOCK_LEN));
    assign close_hit = (cls == CLS_GT) && (hist_reg[0] == CLS_QUES)
                       && (cur_w >= sb_w + (POS_BITS+1)'(1));

    assign ivalid_nl = ivalid_reg && (cls != CLS_NL);

    // opener qualifies when at least one code character sits before "?" (for a block opener, beyond its blank)
    assign iq = ivalid_reg && ({1'b0, ipos_reg} + (POS_BITS+1)'(INLINE_LEN + 2) <= cur_w);
    assign bq = bvalid_reg && ({1'b0, bpos_reg} + (POS_BITS+1)'(BLOCK_LEN + 3) <= cur_w);
    assign use_inline = iq && (!bq || ipos_reg < bpos_reg);
    assign opener     = use_inline ? ipos_reg : bpos_reg;
    assign code_start = use_inline ? opener + POS_BITS'(INLINE_LEN)
                                   : opener + POS_BITS'(BLOCK_LEN);
    assign code_stop  = pos_reg - POS_BITS'(1);

    // state after the character, before end-of-text handling
    always_comb begin
        sb_after    = seg_begin_reg;
        pos_after   = pos_reg;
        ipos_next   = ipos_reg;
        ivalid_next = ivalid_reg;
        bpos_next   = bpos_reg;
        bvalid_next = bvalid_reg;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            hist_next[k] = hist_reg[k];
        end
        c_en[0] = 1'b0;
        c_en[1] = 1'b0;
        if (s_tuser) begin
            hist_next[0] = cls;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                hist_next[k] = hist_reg[k-1];
            end
            ivalid_next = ivalid_nl;
            if (inl_hit && !ivalid_nl) begin
                ipos_next   = pos_reg - POS_BITS'(INLINE_LEN - 1);
                ivalid_next = 1'b1;
            end
            if (blk_hit && !bvalid_reg) begin
                bpos_next   = pos_reg - POS_BITS'(BLOCK_LEN);
                bvalid_next = 1'b1;
            end
            if (close_hit && (iq || bq)) begin
                c_en[0]     = (seg_begin_reg < opener);
                c_en[1]     = 1'b1;
                sb_after    = (pos_reg != POS_MAX) ? pos_reg + POS_BITS'(1) : POS_MAX;
                ivalid_next = 1'b0;
                bvalid_next = 1'b0;
            end
            if (pos_reg != POS_MAX) begin
                pos_after = pos_reg + POS_BITS'(1);
            end
        end
        // tail and end marker on the last transaction
        c_en[2]        = s_tlast && (sb_after < pos_after);
        c_en[3]        = s_tlast;
        seg_begin_next = sb_after;
        pos_next       = pos_after;
        // end of text: back to the reset state
        if (s_tlast) begin
            seg_begin_next = '0;
            pos_next       = '0;
            ipos_next      = '0;
            ivalid_next    = 1'b0;
            bpos_next      = '0;
            bvalid_next    = 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_next[k] = CLS_OTHER;
            end
        end
    end

    // candidate list
    always_comb begin
        c_kind[0]  = SEG_RAW;
        c_start[0] = seg_begin_reg;
        c_end[0]   = opener;
        c_kind[1]  = use_inline ? SEG_INLINE : SEG_BLOCK;
        c_start[1] = code_start;
        c_end[1]   = code_stop;
        c_kind[2]  = SEG_RAW;
        c_start[2] = sb_after;
        c_end[2]   = pos_after;
        c_kind[3]  = SEG_END;
        c_start[3] = '0;
        c_end[3]   = '0;
    end

    // pack enabled candidates into consecutive slots (at most three are set)
    always_comb begin
        c_n = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_kind[i]  = SEG_END;
            n_start[i] = '0;
            n_end[i]   = '0;
            n_last[i]  = 1'b0;
        end
        for (int i = 0; i < 4; i++) begin
            if (c_en[i] && c_n < 3'(MAX_RESULTS)) begin
                n_kind[c_n[1:0]]  = c_kind[i];
                n_start[c_n[1:0]] = c_start[i];
                n_end[c_n[1:0]]   = c_end[i];
                c_n = c_n + 3'd1;
            end
        end
        n_count = c_n[1:0];
        for (int i = 0; i < MAX_RESULTS; i++) begin
            n_last[i] = (3'(i) + 3'd1 == c_n);
        end
    end

    // tracking registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            seg_begin_reg <= '0;
            bpos_reg      <= '0;
            bvalid_reg    <= 1'b0;
            ipos_reg      <= '0;
            ivalid_reg    <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= CLS_OTHER;
            end
        end else if (s_accept) begin
            pos_reg       <= pos_next;
            seg_begin_reg <= seg_begin_next;
            bpos_reg      <= bpos_next;
            bvalid_reg    <= bvalid_next;
            ipos_reg      <= ipos_next;
            ivalid_reg    <= ivalid_next;
            for (int k = 0; k < HIST_DEPTH; k++) begin
                hist_reg[k] <= hist_next[k];
            end
        end
    end

    // result queue count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_count_reg <= 2'd0;
        end else if (s_accept) begin
            q_count_reg <= n_count;
        end else if (m_pop) begin
            q_count_reg <= q_count_reg - 2'd1;
        end
    end

    // result queue payload: load on accept, shift toward the head on pop
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                q_kind_reg[i]  <= n_kind[i];
                q_start_reg[i] <= n_start[i];
                q_end_reg[i]   <= n_end[i];
                q_last_reg[i]  <= n_last[i];
            end
        end else if (m_pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                q_kind_reg[i]  <= q_kind_reg[i+1];
                q_start_reg[i] <= q_start_reg[i+1];
                q_end_reg[i]   <= q_end_reg[i+1];
                q_last_reg[i]  <= q_last_reg[i+1];
            end
        end
    end

endmodule

/* verif/testbench.sv */
// self-checking testbench for the template code segmenter
`timescale 1ns / 1ps

module testbench;
    import tcs_pkg::*;

    localparam int POS_W          = 16;
    localparam int CODE_W         = 21;
    localparam int POS_TOP        = (1 << POS_W) - 1;
    localparam int CODE_TOP       = 1114111;
    localparam int WATCHDOG_LIMIT = 3000;   // idle cycles with no transaction on either side
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 120;    // long receiver stall, fills the result queue
    localparam int ITEMS_PER_PASS = 60;

    // one expected segment on the result side
    typedef struct packed {
        seg_kind_t         kind;
        logic [POS_W-1:0]  first;
        logic [POS_W-1:0]  stop;
        logic              run_end;
    } segment_t;

    // predictor of the segmenter plus the queue of segments still due
    class seg_scoreboard;
        logic [POS_W-1:0] next_pos;
        logic [POS_W-1:0] seg_origin;
        logic [POS_W-1:0] block_at;
        logic [POS_W-1:0] inline_at;
        logic             block_seen;
        logic             inline_seen;
        cls_t             hist[HIST_DEPTH];
        segment_t         segments_due[$];
        int               mismatches;
        int               segments_ok;
        int               texts_done;
        int               chars_seen;

        function new();
            mismatches  = 0;
            segments_ok = 0;
            texts_done  = 0;
            chars_seen  = 0;
            reset_state();
        endfunction

        function void reset_state();
            next_pos    = '0;
            seg_origin  = '0;
            block_at    = '0;
            inline_at   = '0;
            block_seen  = 1'b0;
            inline_seen = 1'b0;
            foreach (hist[k]) hist[k] = CLS_OTHER;
        endfunction

        function cls_t char_class(logic [CODE_W-1:0] code);
            if (code[CODE_W-1:8] != '0) return CLS_OTHER;
            case (code[7:0])
                CH_NL:   return CLS_NL;
                CH_QUES: return CLS_QUES;
                CH_GT:   return CLS_GT;
                CH_LT:   return CLS_LT;
                CH_EQ:   return CLS_EQ;
                CH_P:    return CLS_P;
                CH_Y:    return CLS_Y;
                CH_T:    return CLS_T;
                CH_H:    return CLS_H;
                CH_O:    return CLS_O;
                CH_N:    return CLS_N;
                CH_TAB:  return CLS_TAB;
                CH_SP:   return CLS_SP;
                default: return CLS_OTHER;
            endcase
        endfunction

        function void push_segment(seg_kind_t kind, logic [POS_W-1:0] a, logic [POS_W-1:0] b);
            segments_due.push_back('{kind, a, b, 1'b0});
        endfunction

        // advance the model by one accepted input transaction
        function void note_item(logic [CODE_W-1:0] code, logic present, logic last_item);
            int   cur;
            int   code_stop;
            int   opener;
            int   due_before;
            int   k;
            bit   inl_q;
            bit   blk_q;
            bit   pick_inline;
            cls_t c;
            due_before = segments_due.size();
            if (present) begin
                cur = int'(next_pos);
                c = char_class(code);
                chars_seen++;
                for (k = HIST_DEPTH - 1; k > 0; k--) hist[k] = hist[k - 1];
                hist[0] = c;

                // a newline ends any pending inline opener
                if (c == CLS_NL) inline_seen = 1'b0;

                if (c == CLS_EQ && hist[1] == CLS_QUES && hist[2] == CLS_LT &&
                    cur >= 2 && cur - 2 >= int'(seg_origin) && !inline_seen) begin
                    inline_at   = POS_W'(cur - 2);
                    inline_seen = 1'b1;
                end

                if ((c == CLS_SP || c == CLS_NL || c == CLS_TAB) &&
                    hist[1] == CLS_N && hist[2] == CLS_O && hist[3] == CLS_H &&
                    hist[4] == CLS_T && hist[5] == CLS_Y && hist[6] == CLS_P &&
                    hist[7] == CLS_QUES && hist[8] == CLS_LT &&
                    cur >= 8 && cur - 8 >= int'(seg_origin) && !block_seen) begin
                    block_at   = POS_W'(cur - 8);
                    block_seen = 1'b1;
                end

                // closer: only counts with an opener that leaves room for code
                if (c == CLS_GT && hist[1] == CLS_QUES && cur >= 1 &&
                    cur - 1 >= int'(seg_origin)) begin
                    code_stop = cur - 1;
                    inl_q = inline_seen && int'(inline_at) + INLINE_LEN + 1 <= code_stop;
                    blk_q = block_seen && int'(block_at) + BLOCK_LEN + 2 <= code_stop;
                    if (inl_q || blk_q) begin
                        pick_inline = inl_q && (!blk_q || inline_at < block_at);
                        opener = pick_inline ? int'(inline_at) : int'(block_at);
                        if (int'(seg_origin) < opener)
                            push_segment(SEG_RAW, seg_origin, POS_W'(opener));
                        if (pick_inline)
                            push_segment(SEG_INLINE, POS_W'(opener + INLINE_LEN),
                                         POS_W'(code_stop));
                        else
                            push_segment(SEG_BLOCK, POS_W'(opener + BLOCK_LEN),
                                         POS_W'(code_stop));
                        seg_origin  = (cur < POS_TOP) ? POS_W'(cur + 1) : POS_W'(POS_TOP);
                        inline_seen = 1'b0;
                        block_seen  = 1'b0;
                    end
                end

                if (int'(next_pos) < POS_TOP) next_pos = next_pos + 1'b1;
            end

            if (last_item) begin
                if (seg_origin < next_pos) push_segment(SEG_RAW, seg_origin, next_pos);
                push_segment(SEG_END, '0, '0);
                reset_state();
                texts_done++;
            end

            if (segments_due.size() > due_before)
                segments_due[segments_due.size() - 1].run_end = 1'b1;
        endfunction

        task report_mismatch(string msg);
            // keep the log short if the block is badly off
            if (mismatches < 40) $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // compare one accepted result transaction with the oldest segment due
        task check_result(logic [1:0] kind, logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                          logic run_end);
            segment_t want;
            if (segments_due.size() == 0) begin
                report_mismatch($sformatf("unexpected segment kind %0d [%0d,%0d) last %0b",
                                          kind, a, b, run_end));
                return;
            end
            want = segments_due.pop_front();
            if (kind !== want.kind || a !== want.first || b !== want.stop ||
                run_end !== want.run_end)
                report_mismatch($sformatf(
                    "got kind %0d [%0d,%0d) last %0b, wanted kind %0d [%0d,%0d) last %0b",
                    kind, a, b, run_end, want.kind, want.first, want.stop, want.run_end));
            else
                segments_ok++;
        endtask

        function int outstanding();
            return segments_due.size();
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [23:0]              s_tdata;   // char_code
    logic                     s_tuser;   // char_present
    logic                     s_tlast;   // is_last
    logic                     m_tvalid;
    logic                     m_tready;
    logic [2*POS_W-1:0]       m_tdata;   // seg_start, seg_end
    logic [1:0]               m_tuser;   // seg_type
    logic                     m_tlast;   // last_of_run

    seg_scoreboard sb = new();

    int src_idle = 0;       // percent of cycles the sender holds back
    int dst_idle = 0;       // percent of cycles the receiver holds back
    int hold_len = 0;       // set once by the stimulus to request the long stall
    int held = 0;           // stall cycles spent so far, receiver process only
    int items_sent = 0;     // counted random input transactions
    int stall_cycles = 0;

    template_code_segmenter #(
        .POS_BITS  (POS_W),
        .CHAR_BITS (CODE_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure, plus one long stall on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_len != 0 && held < hold_len) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= dst_idle);
            end
        end
    end

    // result checking and watchdog, both on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[POS_W-1:0], m_tdata[2*POS_W-1:POS_W], m_tlast);
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // offer one input transaction, starting and ending at a falling edge
    task automatic push_item(input logic [CODE_W-1:0] code, input logic present,
                             input logic last_item);
        while ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code};
        s_tuser  <= present;
        s_tlast  <= last_item;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(code, present, last_item);
        @(negedge aclk);
    endtask

    task automatic push_string(input string s, input bit last_on_final);
        int k;
        for (k = 0; k < s.len(); k++)
            push_item(CODE_W'(s[k]), 1'b1, last_on_final && k == s.len() - 1);
    endtask

    function automatic void add_str(ref logic [CODE_W-1:0] txt[$], input string s);
        int k;
        for (k = 0; k < s.len(); k++) txt.push_back(CODE_W'(s[k]));
    endfunction

    // characters biased toward the ones the segmenter reacts to
    function automatic logic [CODE_W-1:0] pick_char();
        string alpha = "<?=>python \n\t<?>ab";
        int r = $urandom_range(0, 99);
        if (r < 55)
            return CODE_W'(alpha[$urandom_range(0, alpha.len() - 1)]);
        else if (r < 80)
            return CODE_W'("a") + CODE_W'($urandom_range(0, 25));
        else if (r < 88)
            return CODE_W'($urandom_range(0, CODE_TOP));
        else if (r < 94)
            return CODE_W'($urandom_range(21'h100000, CODE_TOP));
        else
            // markup byte in the low bits of a non-ascii code point
            return (CODE_W'($urandom_range(1, 4351)) << 8) |
                   CODE_W'(alpha[$urandom_range(0, alpha.len() - 1)]);
    endfunction

    function automatic logic [CODE_W-1:0] pick_code_char();
        if ($urandom_range(0, 99) < 70) return CODE_W'("a") + CODE_W'($urandom_range(0, 25));
        return pick_char();
    endfunction

    // mostly well-formed markup with random content, some broken pieces and noise
    function automatic void build_text(ref logic [CODE_W-1:0] txt[$]);
        string broken[8] = '{"<?=?>", "<?python?>", "<?python ?>", "<?pyth",
                             "?>", "<?= \nx?>", "<?<?=a?>", "<?python\t<?=q?>"};
        string ws = " \n\t";
        int pieces = $urandom_range(0, 4);
        int n;
        int r;
        repeat (pieces) begin
            r = $urandom_range(0, 99);
            n = $urandom_range(0, 4);
            repeat (n) txt.push_back(pick_char());
            if (r < 35) begin
                add_str(txt, "<?=");
                n = $urandom_range(0, 5);
                repeat (n) txt.push_back(pick_code_char());
                add_str(txt, "?>");
            end else if (r < 65) begin
                add_str(txt, "<?python");
                txt.push_back(CODE_W'(ws[$urandom_range(0, 2)]));
                n = $urandom_range(0, 5);
                repeat (n) txt.push_back(pick_code_char());
                add_str(txt, "?>");
            end else if (r < 82) begin
                add_str(txt, broken[$urandom_range(0, 7)]);
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) txt.push_back(pick_char());
            end
        end
    endfunction

    // send one text; shuffled mode sprinkles ignored items and varies the ending
    task automatic send_text(ref logic [CODE_W-1:0] txt[$], input bit shuffled);
        bit absent_end;
        int k;
        absent_end = (txt.size() == 0) || (shuffled && $urandom_range(0, 99) < 20);
        for (k = 0; k < txt.size(); k++) begin
            if (shuffled && $urandom_range(0, 99) < 5)
                push_item(CODE_W'($urandom_range(0, CODE_TOP)), 1'b0, 1'b0);
            push_item(txt[k], 1'b1, !absent_end && k == txt.size() - 1);
            items_sent++;
        end
        if (absent_end) begin
            push_item(CODE_W'($urandom_range(0, CODE_TOP)), 1'b0, 1'b1);
            items_sent++;
        end
    endtask

    // stop offering and wait until every predicted segment has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
    endtask

    task automatic random_pass(input int goal);
        logic [CODE_W-1:0] txt[$];
        while (items_sent < goal) begin
            txt = {};
            build_text(txt);
            send_text(txt, 1'b1);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // sender sparse-ish, receiver mostly stalled
        src_idle = 38;
        dst_idle = 71;

        // empty text: end marker alone
        push_item('0, 1'b0, 1'b1);
        // raw text, inline code with an ignored item inside, closed by the last item
        push_string("a<?=b", 1'b0);
        push_item('0, 1'b0, 1'b0);
        push_string("?>", 1'b1);
        // block code opened with a tab
        push_string("<?python\tx?>", 1'b1);
        // codes outside ascii, one aliasing '<' in its low byte, then a bare end item
        push_item(21'h10003C, 1'b1, 1'b0);
        push_item(21'h10FFFF, 1'b1, 1'b0);
        push_item('0, 1'b0, 1'b1);
        settle();

        random_pass(ITEMS_PER_PASS);
        settle();

        // swap the idle rates
        src_idle = 71;
        dst_idle = 38;
        random_pass(2 * ITEMS_PER_PASS);
        settle();

        // full rate, starting with a long receiver stall while input keeps coming
        src_idle = 0;
        dst_idle = 0;
        hold_len = HOLD_CYCLES;
        random_pass(3 * ITEMS_PER_PASS);
        settle();

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d texts, %0d characters under three back-pressure mixes",
                 sb.texts_done, sb.chars_seen);
        $display("%0d segments matched, %0d mismatches", sb.segments_ok, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/tcs_pkg.sv
src/template_code_segmenter.sv
verif/testbench.sv
